FILE: rtl/mda_pkg.sv
// ----------------------------------------------------------------------------
// mda_pkg
// Shared widths, limits, sequencer states and saturating adders for the
// moisture deficit accumulator.
// ----------------------------------------------------------------------------
package mda_pkg;

   // request field widths
   localparam int TEMP_W  = 14;
   localparam int RAIN_W  = 16;
   localparam int EVAP_W  = 13;

   // accumulator widths
   localparam int MTEMP_W = 19;
   localparam int DAY_W   = 5;
   localparam int MEVAP_W = 18;
   localparam int MRAIN_W = 21;
   localparam int YMEAN_W = 18;
   localparam int MON_W   = 4;
   localparam int YEVAP_W = 21;
   localparam int YRAIN_W = 25;

   // response widths
   localparam int MEAN_W  = 14;
   localparam int RTOT_W  = 25;
   localparam int ETOT_W  = 21;

   // shared divider: dividend magnitude, divisor, step counter
   localparam int DIV_N_W   = 18;
   localparam int DIV_D_W   = 5;
   localparam int DIV_CNT_W = 5;

   localparam logic [DAY_W-1:0] MAX_DAYS   = 5'd31;
   localparam logic [MON_W-1:0] MAX_MONTHS = 4'd12;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DAY,
      ST_MSTART,
      ST_MDIV,
      ST_MCLOSE,
      ST_MYEAR,
      ST_YSTART,
      ST_YDIV,
      ST_EMIT
   } mda_state_type;

   // saturating add, 21-bit
   function automatic logic [20:0] sat_add_21(input logic [20:0] a, input logic [20:0] b);
      logic [21:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[21] ? {21{1'b1}} : s[20:0];
   endfunction

   // saturating add, 25-bit
   function automatic logic [24:0] sat_add_25(input logic [24:0] a, input logic [24:0] b);
      logic [25:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[25] ? {25{1'b1}} : s[24:0];
   endfunction

endpackage

FILE: rtl/mda_div.sv
// ----------------------------------------------------------------------------
// mda_div
// Shared restoring divider: unsigned magnitude by a small unsigned divisor,
// one quotient bit per cycle. Done pulses for one cycle when the quotient
// is ready.
// ----------------------------------------------------------------------------
module mda_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [mda_pkg::DIV_N_W-1:0] dividend,
   input  logic [mda_pkg::DIV_D_W-1:0] divisor,
   output logic                        done,
   output logic [mda_pkg::DIV_N_W-1:0] quotient
);
   import mda_pkg::*;

   localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_N_W - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_D_W-1:0]   rem_ff, rem_in;
   logic [DIV_N_W-1:0]   quo_ff, quo_in;
   logic [DIV_D_W-1:0]   dvs_ff, dvs_in;
   logic [DIV_D_W:0]     trial;
   logic [DIV_D_W:0]     diff;
   logic                 fits;

   // one trial subtraction per step
   assign trial = {rem_ff, quo_ff[DIV_N_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
         quo_in = {quo_ff[DIV_N_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: rtl/moisture_deficit_accumulator_core.sv
// ----------------------------------------------------------------------------
// moisture_deficit_accumulator_core
// Daily temperature, rain and evapotranspiration sums per month and per year,
// with monthly or annual records of mean temperature, totals, deficit and
// surplus.
// ----------------------------------------------------------------------------
// Sequence: a day that does not close a month passes ST_DAY and returns to
//   ST_IDLE; a month end, and a year end in annual mode, also wait on the
//   18-step shared divider used for each mean.
// Throughput: one request at a time; req_ready is high only between requests.
//   The response register lets the next request in while a record waits.
// Reset: synchronous, clears all sums, counters, annual_mode and rsp_valid.
module moisture_deficit_accumulator_core (
   input  logic                        clock,
   input  logic                        reset,
   // configuration
   input  logic                        csr_wr_en,
   input  logic                        csr_wr_data,
   // request channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [mda_pkg::TEMP_W-1:0] req_air_temp,
   input  logic [mda_pkg::RAIN_W-1:0]  req_rain,
   input  logic [mda_pkg::EVAP_W-1:0]  req_evap_ref,
   input  logic                        req_month_end,
   input  logic                        req_year_end,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [mda_pkg::MEAN_W-1:0] rsp_mean_temp,
   output logic [mda_pkg::RTOT_W-1:0]  rsp_rain_total,
   output logic [mda_pkg::ETOT_W-1:0]  rsp_evap_total,
   output logic [mda_pkg::ETOT_W-1:0]  rsp_deficit,
   output logic [mda_pkg::RTOT_W-1:0]  rsp_surplus
);
   import mda_pkg::*;

   mda_state_type state_ff, state_in;

   logic annual_mode_ff;

   // latched request
   logic [TEMP_W-1:0] in_temp_ff;
   logic [RAIN_W-1:0] in_rain_ff;
   logic [EVAP_W-1:0] in_evap_ff;
   logic              mend_ff, yend_ff;

   // month and year accumulators
   logic [MTEMP_W-1:0] month_temp_sum_ff;
   logic [DAY_W-1:0]   day_count_ff;
   logic [MEVAP_W-1:0] month_evap_sum_ff;
   logic [MRAIN_W-1:0] month_rain_sum_ff;
   logic [YMEAN_W-1:0] year_mean_sum_ff;
   logic [MON_W-1:0]   month_count_ff;
   logic [YEVAP_W-1:0] year_evap_sum_ff;
   logic [YRAIN_W-1:0] year_rain_sum_ff;
   logic [YEVAP_W-1:0] year_deficit_sum_ff;
   logic [YRAIN_W-1:0] year_surplus_sum_ff;

   // period record under construction
   logic [MEAN_W-1:0] res_mean_ff;
   logic [RTOT_W-1:0] res_rain_ff;
   logic [ETOT_W-1:0] res_evap_ff;
   logic [ETOT_W-1:0] res_def_ff;
   logic [RTOT_W-1:0] res_sur_ff;

   // response register
   logic              rsp_valid_ff;
   logic [MEAN_W-1:0] rsp_mean_ff;
   logic [RTOT_W-1:0] rsp_rain_ff;
   logic [ETOT_W-1:0] rsp_evap_ff;
   logic [ETOT_W-1:0] rsp_def_ff;
   logic [RTOT_W-1:0] rsp_sur_ff;

   // divider hookup
   logic               div_start, div_done;
   logic [DIV_N_W-1:0] div_dividend, div_quotient;
   logic [DIV_D_W-1:0] div_divisor;
   logic               div_neg_ff;
   logic               div_neg;
   logic [DIV_N_W-1:0] month_mag, year_mag;
   logic [DIV_N_W-1:0] q_signed;

   // sequencer strobes
   logic do_day, do_mclose, do_year, mean_load, year_res_load, emit_load;

   // month close values
   logic [ETOT_W-1:0] m_evap, m_rain, m_def, m_sur;

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_DAY;
         ST_DAY:    state_in = mend_ff ? ST_MSTART : ST_IDLE;
         ST_MSTART: state_in = ST_MDIV;
         ST_MDIV:   if (div_done) state_in = ST_MCLOSE;
         ST_MCLOSE: state_in = ST_MYEAR;
         ST_MYEAR: begin
            priority if (!annual_mode_ff) state_in = ST_EMIT;
            else if (yend_ff)             state_in = ST_YSTART;
            else                          state_in = ST_IDLE;
         end
         ST_YSTART: state_in = ST_YDIV;
         ST_YDIV:   if (div_done) state_in = ST_EMIT;
         ST_EMIT:   if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- strobes
   always_comb begin
      req_ready     = (state_ff == ST_IDLE);
      div_start     = (state_ff == ST_MSTART) || (state_ff == ST_YSTART);
      do_day        = (state_ff == ST_DAY) && (day_count_ff < MAX_DAYS);
      do_mclose     = (state_ff == ST_MCLOSE);
      do_year       = (state_ff == ST_MYEAR) && (month_count_ff < MAX_MONTHS);
      mean_load     = ((state_ff == ST_MDIV) || (state_ff == ST_YDIV)) && div_done;
      year_res_load = (state_ff == ST_YDIV) && div_done;
      emit_load     = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   end

   // ---------------------------------------------------------------- divider operands
   assign month_mag = month_temp_sum_ff[MTEMP_W-1]
                      ? DIV_N_W'(-month_temp_sum_ff) : DIV_N_W'(month_temp_sum_ff);
   assign year_mag  = year_mean_sum_ff[YMEAN_W-1]
                      ? DIV_N_W'(-year_mean_sum_ff) : DIV_N_W'(year_mean_sum_ff);
   assign div_dividend = (state_ff == ST_YSTART) ? year_mag : month_mag;
   assign div_divisor  = (state_ff == ST_YSTART) ? {1'b0, month_count_ff} : day_count_ff;
   assign div_neg      = (state_ff == ST_YSTART) ? year_mean_sum_ff[YMEAN_W-1]
                                                 : month_temp_sum_ff[MTEMP_W-1];
   // quotient back to signed, truncated toward zero
   assign q_signed = div_neg_ff ? (~div_quotient + 1'b1) : div_quotient;

   mda_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // ---------------------------------------------------------------- month close math
   always_comb begin
      m_evap = month_temp_sum_ff[MTEMP_W-1] ? '0 : ETOT_W'(month_evap_sum_ff);
      m_rain = ETOT_W'(month_rain_sum_ff);
      m_def  = (m_evap > m_rain) ? (m_evap - m_rain) : '0;
      m_sur  = (m_rain > m_evap) ? (m_rain - m_evap) : '0;
   end

   // ---------------------------------------------------------------- control regs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         annual_mode_ff <= 1'b0;
         mend_ff        <= 1'b0;
         yend_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) annual_mode_ff <= csr_wr_data;
         if (req_valid && req_ready) begin
            mend_ff <= req_month_end | req_year_end;
            yend_ff <= req_year_end;
         end
         if (emit_load)      rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // ---------------------------------------------------------------- accumulators
   always_ff @(posedge clock) begin
      if (reset) begin
         month_temp_sum_ff   <= '0;
         day_count_ff        <= '0;
         month_evap_sum_ff   <= '0;
         month_rain_sum_ff   <= '0;
         year_mean_sum_ff    <= '0;
         month_count_ff      <= '0;
         year_evap_sum_ff    <= '0;
         year_rain_sum_ff    <= '0;
         year_deficit_sum_ff <= '0;
         year_surplus_sum_ff <= '0;
      end else begin
         // add one day
         if (do_day) begin
            month_temp_sum_ff <= month_temp_sum_ff
                                 + {{(MTEMP_W-TEMP_W){in_temp_ff[TEMP_W-1]}}, in_temp_ff};
            month_evap_sum_ff <= month_evap_sum_ff + MEVAP_W'(in_evap_ff);
            month_rain_sum_ff <= month_rain_sum_ff + MRAIN_W'(in_rain_ff);
            day_count_ff      <= day_count_ff + 1'b1;
         end
         // close the month
         if (do_mclose) begin
            month_temp_sum_ff <= '0;
            month_evap_sum_ff <= '0;
            month_rain_sum_ff <= '0;
            day_count_ff      <= '0;
         end
         // fold the month into the year
         if (do_year) begin
            year_mean_sum_ff    <= year_mean_sum_ff
                                   + {{(YMEAN_W-MEAN_W){res_mean_ff[MEAN_W-1]}}, res_mean_ff};
            year_evap_sum_ff    <= sat_add_21(year_evap_sum_ff, res_evap_ff);
            year_rain_sum_ff    <= sat_add_25(year_rain_sum_ff, res_rain_ff);
            year_deficit_sum_ff <= sat_add_21(year_deficit_sum_ff, res_def_ff);
            year_surplus_sum_ff <= sat_add_25(year_surplus_sum_ff, res_sur_ff);
            month_count_ff      <= month_count_ff + 1'b1;
         end
         // year end clears the annual sums once the record is out
         if (emit_load && yend_ff) begin
            year_mean_sum_ff    <= '0;
            month_count_ff      <= '0;
            year_evap_sum_ff    <= '0;
            year_rain_sum_ff    <= '0;
            year_deficit_sum_ff <= '0;
            year_surplus_sum_ff <= '0;
         end
      end
   end

   // ---------------------------------------------------------------- payload regs
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_temp_ff <= req_air_temp;
         in_rain_ff <= req_rain;
         in_evap_ff <= req_evap_ref;
      end
      if (div_start) div_neg_ff <= div_neg;
      if (mean_load) res_mean_ff <= q_signed[MEAN_W-1:0];
      if (do_mclose) begin
         res_rain_ff <= RTOT_W'(m_rain);
         res_evap_ff <= m_evap;
         res_def_ff  <= m_def;
         res_sur_ff  <= RTOT_W'(m_sur);
      end
      if (year_res_load) begin
         res_rain_ff <= year_rain_sum_ff;
         res_evap_ff <= year_evap_sum_ff;
         res_def_ff  <= year_deficit_sum_ff;
         res_sur_ff  <= year_surplus_sum_ff;
      end
      if (emit_load) begin
         rsp_mean_ff <= res_mean_ff;
         rsp_rain_ff <= res_rain_ff;
         rsp_evap_ff <= res_evap_ff;
         rsp_def_ff  <= res_def_ff;
         rsp_sur_ff  <= res_sur_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mean_temp  = rsp_mean_ff;
   assign rsp_rain_total = rsp_rain_ff;
   assign rsp_evap_total = rsp_evap_ff;
   assign rsp_deficit    = rsp_def_ff;
   assign rsp_surplus    = rsp_sur_ff;

   // ---------------------------------------------------------------- assertions
   a_day_limit: assert property (@(posedge clock) disable iff (reset)
      day_count_ff <= MAX_DAYS)
      else $error("day count beyond month limit");

   a_month_limit: assert property (@(posedge clock) disable iff (reset)
      month_count_ff <= MAX_MONTHS)
      else $error("month count beyond year limit");

   a_month_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MSTART |-> day_count_ff != '0)
      else $error("month mean started with zero days");

   a_year_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_YSTART |-> month_count_ff != '0)
      else $error("annual mean started with zero months");

   a_div_done_owned: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_MDIV || state_ff == ST_YDIV))
      else $error("divider finished outside a divide state");

endmodule
